// File: hw/rtl/ilex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilex_pkg: shared types and constants of the integer literal lexer
// Scan modes, token kinds, the result record and the result queue sizing.
// ----------------------------------------------------------------------------
package ilex_pkg;

	// Default accumulator width.
	localparam int VALUE_WIDTH_DEF = 32;

	// Width of the number field on the result channel.
	localparam int NUM_W = 32;

	// Result queue depth (power of two) and its pointer width.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_DEC,
		MODE_ZERO,
		MODE_HEX_PRE,
		MODE_HEX,
		MODE_BIN_PRE,
		MODE_BIN,
		MODE_OCT
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NUMBER,
		KIND_NO_DIGITS,
		KIND_IDENT,
		KIND_UNKNOWN
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [NUM_W-1:0]  value;
		logic [7:0]        bad;
		logic              last;
	} result_t;

endpackage

// File: hw/rtl/ilex_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilex_step: one character step of the lexer
// Computes the next scan mode and accumulator and up to two result tokens.
// ----------------------------------------------------------------------------
module ilex_step #(
	parameter int VALUE_WIDTH = ilex_pkg::VALUE_WIDTH_DEF
) (
	input  ilex_pkg::mode_t          mode,
	input  logic [VALUE_WIDTH-1:0]   acc,
	input  logic [7:0]               char_code,
	input  logic                     end_of_input,
	output ilex_pkg::mode_t          mode_next,
	output logic [VALUE_WIDTH-1:0]   acc_next,
	output logic [1:0]               res_count,
	output ilex_pkg::result_t        res0,
	output ilex_pkg::result_t        res1
);
	import ilex_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam int         CW       = (VALUE_WIDTH < NUM_W) ? VALUE_WIDTH : NUM_W;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	logic [3:0]             digit;
	logic                   hex_ok;
	logic                   consumed;
	mode_t                  ext_mode;
	logic [VALUE_WIDTH-1:0] ext_acc;
	logic [VALUE_WIDTH-1:0] dig_ext;
	logic                   pending;
	logic                   is_blank;
	logic                   is_unknown;
	result_t                pend_tok;
	result_t                unk_tok;

	// Character decode and the attempt to extend the pending token.
	always_comb begin
		digit   = char_code[3:0];
		hex_ok  = is_dec(char_code);
		if ((char_code >= "A" && char_code <= "F") ||
			(char_code >= "a" && char_code <= "f")) begin
			digit  = 4'(char_code[3:0] + 4'd9);
			hex_ok = 1'b1;
		end
		dig_ext  = VALUE_WIDTH'(digit);
		consumed = 1'b0;
		ext_mode = mode;
		ext_acc  = acc;
		case (mode)
			MODE_IDENT: begin
				consumed = is_alpha(char_code) || is_dec(char_code);
			end
			MODE_DEC: begin
				consumed = is_dec(char_code);
				ext_acc  = (acc << 3) + (acc << 1) + dig_ext;
			end
			MODE_ZERO: begin
				if (char_code == "x") begin
					consumed = 1'b1;
					ext_mode = MODE_HEX_PRE;
				end else if (char_code == "b") begin
					consumed = 1'b1;
					ext_mode = MODE_BIN_PRE;
				end else if (char_code >= "0" && char_code <= "7") begin
					consumed = 1'b1;
					ext_mode = MODE_OCT;
					ext_acc  = (acc << 3) + dig_ext;
				end
			end
			MODE_HEX_PRE, MODE_HEX: begin
				consumed = hex_ok;
				ext_mode = MODE_HEX;
				ext_acc  = (acc << 4) + dig_ext;
			end
			MODE_BIN_PRE, MODE_BIN: begin
				consumed = char_code == "0" || char_code == "1";
				ext_mode = MODE_BIN;
				ext_acc  = (acc << 1) + dig_ext;
			end
			MODE_OCT: begin
				consumed = char_code >= "0" && char_code <= "7";
				ext_acc  = (acc << 3) + dig_ext;
			end
			default: begin
				consumed = 1'b0;
			end
		endcase
		pending    = mode != MODE_IDLE;
		is_blank   = char_code == CH_SPACE || char_code == CH_TAB || char_code == CH_LF;
		is_unknown = !is_blank && !is_alpha(char_code) && !is_dec(char_code);
	end

	// Next scan mode and accumulator. The accumulator is zero whenever the
	// scanner is idle, so a new token always starts from zero.
	always_comb begin
		mode_next = MODE_IDLE;
		acc_next  = '0;
		if (!end_of_input) begin
			if (pending && consumed) begin
				mode_next = ext_mode;
				acc_next  = ext_acc;
			end else if (is_alpha(char_code)) begin
				mode_next = MODE_IDENT;
			end else if (char_code == "0") begin
				mode_next = MODE_ZERO;
			end else if (is_dec(char_code)) begin
				mode_next = MODE_DEC;
				acc_next  = dig_ext;
			end
		end
	end

	// Result tokens: the flushed pending token comes first, then an unknown
	// character token when the same character starts no token.
	always_comb begin
		pend_tok       = '0;
		pend_tok.kind  = KIND_NUMBER;
		pend_tok.value = NUM_W'(acc[CW-1:0]);
		case (mode)
			MODE_IDENT: begin
				pend_tok.kind  = KIND_IDENT;
				pend_tok.value = '0;
			end
			MODE_HEX_PRE, MODE_BIN_PRE: begin
				pend_tok.kind  = KIND_NO_DIGITS;
				pend_tok.value = '0;
			end
			default: begin
				pend_tok.kind = KIND_NUMBER;
			end
		endcase
		unk_tok      = '0;
		unk_tok.kind = KIND_UNKNOWN;
		unk_tok.bad  = char_code;

		res_count = 2'd0;
		res0      = pend_tok;
		res1      = unk_tok;
		if (end_of_input) begin
			res_count = pending ? 2'd1 : 2'd0;
			res0.last = 1'b1;
		end else if (!(pending && consumed)) begin
			if (pending && is_unknown) begin
				res_count = 2'd2;
				res1.last = 1'b1;
			end else if (pending) begin
				res_count = 2'd1;
				res0.last = 1'b1;
			end else if (is_unknown) begin
				res_count = 2'd1;
				res0      = unk_tok;
				res0.last = 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/ilex_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilex_out_fifo: result queue of the lexer
// Takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module ilex_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_count,
	input  ilex_pkg::result_t   push0,
	input  ilex_pkg::result_t   push1,
	output logic                room_for_two,
	output logic                out_valid,
	input  logic                out_ready,
	output ilex_pkg::result_t   head
);
	import ilex_pkg::*;

	result_t                mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   count_q;
	logic                   pop;

	assign out_valid    = count_q != '0;
	assign pop          = out_valid && out_ready;
	assign head         = mem_q[rd_ptr_q];
	assign room_for_two = count_q <= OUT_CNT_W'(OUT_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push_count);
			rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(pop);
			count_q  <= count_q + OUT_CNT_W'(push_count) - OUT_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[OUT_PTR_W'(wr_ptr_q + 1'b1)] <= push1;
		end
	end

endmodule

// File: hw/rtl/integer_literal_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_lexer: streaming lexer for C-style integer literals
// One source byte per transfer in, one token per transfer out.
// ----------------------------------------------------------------------------
// The lexer takes one character per cycle while in_ready is high and answers
// each with zero, one or two tokens: decimal, 0x hex, 0b binary and 0-prefixed
// octal literals as numbers (value modulo 2^VALUE_WIDTH, low 32 bits shown), a
// bare prefix as a missing-digits token, identifier runs as one token, and any
// other non-blank byte as an unknown-character token. A character is absorbed
// in the cycle it is accepted; the scan mode and accumulator registers update
// at that edge and its tokens enter a four-entry result queue, which is read
// one token per cycle while out_ready is high. Input is taken whenever at
// least two queue slots are free, so a steady stream runs at one character
// per cycle while the result side keeps up; a character that yields two
// tokens costs the result side two transfers, and the queue depth sets how far
// input runs ahead of a stalled result side. An end-of-input item flushes the
// pending token and returns the scanner to idle.
// ----------------------------------------------------------------------------
module integer_literal_lexer #(
	parameter int VALUE_WIDTH = ilex_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  token_kind,
	output logic [31:0] number_value,
	output logic [7:0]  bad_char,
	output logic        last_result
);
	import ilex_pkg::*;

	mode_t                  mode_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	mode_t                  mode_next;
	logic [VALUE_WIDTH-1:0] acc_next;
	logic [1:0]             res_count;
	logic [1:0]             push_count;
	result_t                res0;
	result_t                res1;
	result_t                head;
	logic                   room_for_two;
	logic                   in_xfer;

	// Input is taken whenever the queue can absorb the worst case of two tokens.
	assign in_ready   = room_for_two;
	assign in_xfer    = in_valid && in_ready;
	assign push_count = in_xfer ? res_count : 2'd0;

	ilex_step #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_step (
		.mode         (mode_q),
		.acc          (acc_q),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.mode_next    (mode_next),
		.acc_next     (acc_next),
		.res_count    (res_count),
		.res0         (res0),
		.res1         (res1)
	);

	// Scanner state advances only on an accepted input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
		end else if (in_xfer) begin
			mode_q <= mode_next;
			acc_q  <= acc_next;
		end
	end

	ilex_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (push_count),
		.push0        (res0),
		.push1        (res1),
		.room_for_two (room_for_two),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.head         (head)
	);

	assign token_kind   = 2'(head.kind);
	assign number_value = head.value;
	assign bad_char     = head.bad;
	assign last_result  = head.last;

	// An end-of-input transfer always leaves the scanner idle.
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && end_of_input |=> mode_q == MODE_IDLE)
		else $error("scanner not idle after end of input");

	// The accumulator is cleared whenever no token is pending.
	a_idle_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> acc_q == '0)
		else $error("accumulator not zero while idle");

	// Only number tokens carry a value.
	a_value_only_numbers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != 2'(KIND_NUMBER) |-> number_value == '0)
		else $error("non-number token carries a value");

	// Only unknown-character tokens carry a character.
	a_bad_only_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != 2'(KIND_UNKNOWN) |-> bad_char == '0)
		else $error("token other than unknown carries a character");

endmodule

// File: tb/integer_literal_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_lexer_tb: self-checking bench for the integer literal lexer
// Feeds characters through the input channel and checks every token against
// a cycle-free model of the scanner. Both sides idle at random, and the
// result side holds off for long stretches so that input backs up.
// ----------------------------------------------------------------------------
module integer_literal_lexer_tb;
	import ilex_pkg::*;

	// Character codes the scanner cares about.
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ZERO       = "0";
	localparam logic [7:0] CH_ONE        = "1";
	localparam logic [7:0] CH_SEVEN      = "7";
	localparam logic [7:0] CH_NINE       = "9";
	localparam logic [7:0] CH_UPPER_A    = "A";
	localparam logic [7:0] CH_UPPER_F    = "F";
	localparam logic [7:0] CH_UPPER_Z    = "Z";
	localparam logic [7:0] CH_UNDERSCORE = "_";
	localparam logic [7:0] CH_LOWER_A    = "a";
	localparam logic [7:0] CH_LOWER_B    = "b";
	localparam logic [7:0] CH_LOWER_F    = "f";
	localparam logic [7:0] CH_LOWER_X    = "x";
	localparam logic [7:0] CH_LOWER_Z    = "z";

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Letters and underscore: the characters that may open an identifier.
	function automatic bit is_word_char(logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
			c == CH_UNDERSCORE;
	endfunction

	// Tracks the scanner state for every accepted character, queues the tokens it
	// must produce and compares them with the tokens that come out.
	class token_checker;
		mode_t       scan;
		logic [31:0] acc;
		result_t     expected_tokens[$];
		result_t     held;
		bit          have_held;
		int          errors;
		int          chars;
		int          ends;
		int          seen[4];

		function new();
			scan      = MODE_IDLE;
			acc       = '0;
			have_held = 1'b0;
			errors    = 0;
			chars     = 0;
			ends      = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		// Appends one token at the tail of the expected queue.
		function void add_expected(result_t t);
			expected_tokens.insert(expected_tokens.size(), t);
		endfunction

		// A token is held back one slot so that the last one of a character can
		// be marked once the whole character has been handled.
		function void emit(kind_t kind, logic [31:0] value, logic [7:0] bad);
			if (have_held) add_expected(held);
			held.kind  = kind;
			held.value = value;
			held.bad   = bad;
			held.last  = 1'b0;
			have_held  = 1'b1;
		endfunction

		// Emit whatever token is open and go back to idle.
		function void close_token();
			case (scan)
				MODE_IDENT:                 emit(KIND_IDENT, '0, '0);
				MODE_HEX_PRE, MODE_BIN_PRE: emit(KIND_NO_DIGITS, '0, '0);
				MODE_DEC, MODE_ZERO, MODE_HEX, MODE_BIN, MODE_OCT: emit(KIND_NUMBER, acc, '0);
				default: ;
			endcase
			scan = MODE_IDLE;
			acc  = '0;
		endfunction

		function void lex_char(logic [7:0] c, logic eoi);
			logic [31:0] digit;
			bit          took;
			bit          hex_lower;
			bit          hex_upper;
			chars++;
			digit     = {24'd0, c - CH_ZERO};
			hex_lower = c >= CH_LOWER_A && c <= CH_LOWER_F;
			hex_upper = c >= CH_UPPER_A && c <= CH_UPPER_F;
			if (eoi) begin
				ends++;
				close_token();
			end else begin
				// First try to extend the open token.
				took = 1'b0;
				case (scan)
					MODE_IDENT: took = is_word_char(c) || is_digit(c);
					MODE_DEC: if (is_digit(c)) begin
						acc  = acc * 10 + digit;
						took = 1'b1;
					end
					MODE_ZERO: if (c == CH_LOWER_X) begin
						scan = MODE_HEX_PRE;
						took = 1'b1;
					end else if (c == CH_LOWER_B) begin
						scan = MODE_BIN_PRE;
						took = 1'b1;
					end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
						scan = MODE_OCT;
						acc  = acc * 8 + digit;
						took = 1'b1;
					end
					MODE_HEX_PRE, MODE_HEX: if (is_digit(c) || hex_lower || hex_upper) begin
						if (hex_lower) digit = {24'd0, c - CH_LOWER_A} + 10;
						if (hex_upper) digit = {24'd0, c - CH_UPPER_A} + 10;
						scan = MODE_HEX;
						acc  = acc * 16 + digit;
						took = 1'b1;
					end
					MODE_BIN_PRE, MODE_BIN: if (c == CH_ZERO || c == CH_ONE) begin
						scan = MODE_BIN;
						acc  = acc * 2 + digit;
						took = 1'b1;
					end
					MODE_OCT: if (c >= CH_ZERO && c <= CH_SEVEN) begin
						acc  = acc * 8 + digit;
						took = 1'b1;
					end
					default: ;
				endcase
				// The character did not fit: close the open token, then let the
				// character start the next one.
				if (!took) begin
					close_token();
					if (is_blank(c)) begin
					end else if (is_word_char(c)) begin
						scan = MODE_IDENT;
					end else if (c == CH_ZERO) begin
						scan = MODE_ZERO;
						acc  = '0;
					end else if (is_digit(c)) begin
						scan = MODE_DEC;
						acc  = digit;
					end else begin
						emit(KIND_UNKNOWN, '0, c);
					end
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				add_expected(held);
				have_held = 1'b0;
			end
		endfunction

		function void check_token(logic [1:0] kind, logic [31:0] value, logic [7:0] bad,
				logic last);
			result_t want;
			if (!$isunknown(kind)) seen[kind]++;
			if (expected_tokens.size() == 0) begin
				if (errors < 10)
					$display("Mismatch: token kind %0d value %h bad %h last %b, none expected",
						kind, value, bad, last);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			if (kind !== want.kind || value !== want.value || bad !== want.bad ||
					last !== want.last) begin
				if (errors < 10) begin
					$display("Mismatch: expected kind %0d value %h bad %h last %b",
						want.kind, want.value, want.bad, want.last);
					$display("          actual   kind %0d value %h bad %h last %b",
						kind, value, bad, last);
				end
				errors++;
			end
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction
	endclass

	// Number of input transfers to send in total.
	localparam int ITEM_TARGET     = 1850;
	// Cycles with no transfer on either side before the run is declared hung.
	// The slowest legal stretch is a result-side hold-off of HOLD_OFF_CYCLES.
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	// Drain margin after the last expected token; it covers the result queue.
	localparam int DRAIN_CYCLES    = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  token_kind;
	logic [31:0] number_value;
	logic [7:0]  bad_char;
	logic        last_result;

	token_checker token_check = new();

	int sent_items = 0;
	int holds_done = 0;
	int next_hold  = 500;
	bit hold_off_req = 1'b0;
	// While set, the sender offers characters back to back.
	bit burst = 1'b0;

	integer_literal_lexer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.number_value (number_value),
		.bad_char     (bad_char),
		.last_result  (last_result)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	// A letter, an underscore or, when allowed, a digit.
	function automatic logic [7:0] rand_word_char(bit allow_digit);
		int r;
		r = $urandom_range(0, allow_digit ? 62 : 52);
		if (r < 26) return 8'(CH_LOWER_A + r);
		if (r < 52) return 8'(CH_UPPER_A + r - 26);
		if (r == 52) return CH_UNDERSCORE;
		return 8'(CH_ZERO + r - 53);
	endfunction

	// Offers one character and waits for its transfer. The valid line is only
	// dropped when a gap is taken, so back-to-back transfers keep it high.
	task automatic send_char(input logic [7:0] c, input logic eoi);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
		token_check.lex_char(c, eoi);
		sent_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
	endtask

	// One token of random shape. Most are well-formed literals and identifiers
	// with random content; the rest are bare prefixes, a leading zero followed
	// by a digit or letter that breaks it, stray bytes, end marks and blank runs.
	task automatic send_random_token();
		int          form;
		int          len;
		int          r;
		bit          all_f;
		string       s;
		logic [7:0]  c;
		form = $urandom_range(0, 99);
		if (form < 18) begin
			// Decimal; the long ones wrap the accumulator.
			send_char(8'(CH_ONE + $urandom_range(0, 8)), 1'b0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 5);
			repeat (len) send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
		end else if (form < 32) begin
			// Hex in either letter case; a run of f digits reaches all ones.
			send_text("0x");
			r     = $urandom_range(0, 9);
			len   = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 8) : $urandom_range(9, 12);
			all_f = $urandom_range(0, 7) == 0;
			if (all_f) len = $urandom_range(8, 10);
			repeat (len) begin
				r = $urandom_range(0, 21);
				if (all_f)       c = $urandom_range(0, 1) ? CH_LOWER_F : CH_UPPER_F;
				else if (r < 10) c = 8'(CH_ZERO + r);
				else if (r < 16) c = 8'(CH_LOWER_A + r - 10);
				else             c = 8'(CH_UPPER_A + r - 16);
				send_char(c, 1'b0);
			end
		end else if (form < 42) begin
			send_text("0b");
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			repeat (len) send_char($urandom_range(0, 1) ? CH_ONE : CH_ZERO, 1'b0);
		end else if (form < 52) begin
			// Octal, or a lone zero when no digits follow.
			send_char(CH_ZERO, 1'b0);
			len = $urandom_range(0, 12);
			repeat (len) send_char(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0);
		end else if (form < 56) begin
			case ($urandom_range(0, 3))
				0:       s = "08";
				1:       s = "09";
				2:       s = "0X";
				default: s = "0B";
			endcase
			send_text(s);
		end else if (form < 72) begin
			send_char(rand_word_char(1'b0), 1'b0);
			len = $urandom_range(0, 8);
			repeat (len) send_char(rand_word_char(1'b1), 1'b0);
		end else if (form < 80) begin
			// A byte that can start no token.
			do c = 8'($urandom_range(0, 255)); while (is_blank(c) || is_word_char(c) ||
				is_digit(c));
			send_char(c, 1'b0);
		end else if (form < 90) begin
			send_char(8'($urandom_range(0, 255)), 1'b0);
		end else if (form < 95) begin
			// The character code rides along with the end mark and is ignored.
			send_char(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			len = $urandom_range(1, 3);
			repeat (len) send_char(rand_blank(), 1'b0);
		end
		// Half the tokens run straight into the next one.
		if ($urandom_range(0, 1)) send_char(rand_blank(), 1'b0);
	endtask

	// Every token transfer is checked against the oldest expected token.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			token_check.check_token(token_kind, number_value, bad_char, last_result);
	end

	// Result side: random stalls between runs of readiness. When the sender
	// asks for it, the receiver holds off long enough for the result queue to
	// fill and the input channel to stall.
	initial begin
		int stall;
		int run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200) :
					$urandom_range(1, 30);
				repeat (run) @(posedge clk);
			end
		end
	end

	// Hang detection: ends the run after too many cycles without a transfer.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
			else idle_run++;
		end
		$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Hex with mixed letter case closed by an unknown byte,
		// which gives two tokens at once; a bare binary prefix closed by a
		// letter; an identifier closed by byte FF (two tokens again); byte 00;
		// an upper-case X after zero, which is no prefix; zero followed by 9;
		// upper-case B after zero; octal closed by an end mark; an end mark
		// with nothing open; a bare hex prefix closed by an end mark.
		send_text("0xfA#");
		send_text("0bz");
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_text("0X\t09 0B\n017");
		send_char(8'($urandom_range(0, 255)), 1'b1);
		send_char(8'($urandom_range(0, 255)), 1'b1);
		send_text("0x");
		send_char(8'($urandom_range(0, 255)), 1'b1);

		// Random part, with occasional stretches of back-to-back input and a
		// long result-side hold-off every few hundred items.
		while (sent_items < ITEM_TARGET) begin
			if (sent_items >= next_hold) begin
				hold_off_req = 1'b1;
				next_hold += 700;
			end
			if ($urandom_range(0, 63) == 0) burst = !burst;
			send_random_token();
		end
		in_valid <= 1'b0;

		while (token_check.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Lexed %0d characters including %0d end marks; %0d long hold-offs.",
			token_check.chars, token_check.ends, holds_done);
		$display("Tokens seen: %0d numbers, %0d bare prefixes, %0d identifiers,",
			token_check.seen[KIND_NUMBER], token_check.seen[KIND_NO_DIGITS],
			token_check.seen[KIND_IDENT]);
		$display("%0d unknown bytes; %0d mismatches.",
			token_check.seen[KIND_UNKNOWN], token_check.errors);
		if (token_check.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
